// ----- rtl/core/mwv_pkg.sv -----
`default_nettype none

package mwv_pkg;

	localparam int MAX_WINDOW = 256;
	localparam int SAMPLE_BITS = 16;

	localparam int PTR_W = $clog2(MAX_WINDOW);
	localparam int CNT_W = PTR_W + 1;
	localparam int WLEN_W = 9;
	localparam int DOF_W = 8;
	localparam int SUM_W = SAMPLE_BITS + PTR_W + 1;
	localparam int MAG_W = SUM_W - 1;
	localparam int SQ_W = 2 * SAMPLE_BITS - 1;
	localparam int SUMSQ_W = SQ_W + PTR_W;
	localparam int NUM_W = SUMSQ_W + CNT_W;
	localparam int DEN_W = 2 * CNT_W - 1;
	localparam int VAR_W = 39;
	localparam int STEP_W = $clog2(NUM_W + 1);

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = WLEN_W;

	localparam logic [WLEN_W-1:0] RESET_WINDOW_LEN = WLEN_W'(256);
	localparam logic [DOF_W-1:0] RESET_DOF = DOF_W'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_LEN = 2'd0,
		REG_DOF = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic missing;
	} in_t;

	typedef struct packed {
		logic [VAR_W-1:0] variance;
		logic valid_res;
		logic config_error;
	} out_t;

	typedef struct packed {
		logic upd;
		logic cfg_err;
		logic signed [SAMPLE_BITS-1:0] sample;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] n;
		logic [DOF_W-1:0] dof;
		logic clear;
	} cfg_t;

endpackage

`default_nettype wire

// ----- rtl/core/mwv_front.sv -----
`default_nettype none

module mwv_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [mwv_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [mwv_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input wire logic sample_valid,
	output logic sample_stall,
	input wire mwv_pkg::in_t sample_item,
	input wire logic queue_full,
	output logic push,
	output mwv_pkg::cmd_t push_cmd,
	output mwv_pkg::cfg_t cfg
);
	import mwv_pkg::*;

	logic [WLEN_W-1:0] window_len_q;
	logic [DOF_W-1:0] dof_q;
	logic cfg_we;
	logic [CNT_W-1:0] n_eff;
	logic cfg_err;

	assign cfg_ready = 1'b1;
	assign cfg_we = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= RESET_WINDOW_LEN;
			dof_q <= RESET_DOF;
		end else if (cfg_we) begin
			if (cfg_index == REG_WINDOW_LEN) begin
				window_len_q <= cfg_wdata[WLEN_W-1:0];
			end
			if (cfg_index == REG_DOF) begin
				dof_q <= cfg_wdata[DOF_W-1:0];
			end
		end
	end

	always_comb begin
		if (int'(window_len_q) > MAX_WINDOW) begin
			n_eff = CNT_W'(MAX_WINDOW);
		end else begin
			n_eff = CNT_W'(window_len_q);
		end
	end

	assign cfg_err = int'(n_eff) <= int'(dof_q) + 1;

	assign cfg.n = n_eff;
	assign cfg.dof = dof_q;
	assign cfg.clear = cfg_we && (cfg_index == REG_WINDOW_LEN || cfg_index == REG_DOF);

	assign sample_stall = queue_full;
	assign push = sample_valid && !queue_full;
	assign push_cmd.upd = !cfg_err && !sample_item.missing;
	assign push_cmd.cfg_err = cfg_err;
	assign push_cmd.sample = sample_item.sample;

endmodule

`default_nettype wire

// ----- rtl/core/mwv_queue.sv -----
`default_nettype none

module mwv_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire mwv_pkg::cmd_t push_cmd,
	output logic full,
	input wire logic pop,
	output logic head_valid,
	output mwv_pkg::cmd_t head_cmd
);
	import mwv_pkg::*;

	cmd_t entry_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = count_q == 2'd2;
	assign head_valid = count_q != 2'd0;
	assign head_cmd = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2)
		else $error("queue holds more than two entries");

	a_pointers_track: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with the entry count");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |=> (count_q != 2'd0 || $past(pop)))
		else $error("full queue emptied without a pop");

endmodule

`default_nettype wire

// ----- rtl/core/mwv_div.sv -----
`default_nettype none

module mwv_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [mwv_pkg::NUM_W-1:0] num,
	input wire logic [mwv_pkg::DEN_W-1:0] den,
	output logic busy,
	output logic done,
	output logic [mwv_pkg::NUM_W-1:0] quotient
);
	import mwv_pkg::*;

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [STEP_W-1:0] step_q;
	logic busy_q;
	logic done_q;
	logic [DEN_W:0] rem_sh;
	logic ge;

	assign rem_sh = {rem_q, quo_q[NUM_W-1]};
	assign ge = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], ge};
			if (ge) begin
				rem_q <= DEN_W'(rem_sh - {1'b0, den_q});
			end else begin
				rem_q <= rem_sh[DEN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + STEP_W'(1);
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quotient = quo_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("division started while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("division done without a running division");

endmodule

`default_nettype wire

// ----- rtl/core/mwv_back.sv -----
`default_nettype none

module mwv_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire mwv_pkg::cfg_t cfg,
	input wire logic head_valid,
	input wire mwv_pkg::cmd_t head_cmd,
	output logic pop,
	output logic result_valid,
	input wire logic result_stall,
	output mwv_pkg::out_t result_item
);
	import mwv_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_UPD,
		ST_MUL,
		ST_SUB,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t state_q;

	logic signed [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
	logic signed [SAMPLE_BITS-1:0] ring_rd_q;
	logic ring_we;

	logic [PTR_W-1:0] wp_q;
	logic [CNT_W-1:0] fill_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [SUMSQ_W-1:0] sumsq_q;

	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic signed [SAMPLE_BITS-1:0] old_q;
	logic [SQ_W-1:0] old_sq_q;
	logic [SQ_W-1:0] new_sq_q;
	logic report_q;

	logic [NUM_W-1:0] prod_a_q;
	logic [NUM_W-1:0] prod_b_q;
	logic [DEN_W-1:0] den_q;
	logic div_start;
	logic div_busy;
	logic div_done;
	logic [NUM_W-1:0] div_quo;

	out_t pend_q;
	out_t res_q;
	logic res_valid_q;
	logic load_ok;
	logic res_load;

	logic fill_full;
	logic [CNT_W-1:0] fill_next;
	logic signed [2*SAMPLE_BITS-1:0] old_prod;
	logic signed [2*SAMPLE_BITS-1:0] new_prod;
	logic [MAG_W-1:0] mag;
	logic [CNT_W-1:0] n_minus_dof;

	assign fill_full = fill_q >= cfg.n;
	assign fill_next = fill_full ? fill_q : fill_q + CNT_W'(1);
	assign old_prod = ring_rd_q * ring_rd_q;
	assign new_prod = sample_q * sample_q;
	assign mag = sum_q[SUM_W-1] ? MAG_W'(-sum_q) : MAG_W'(sum_q);
	assign n_minus_dof = cfg.n - CNT_W'(cfg.dof);

	assign pop = state_q == ST_IDLE && head_valid;
	assign ring_we = state_q == ST_READ;
	assign div_start = state_q == ST_SUB && !div_busy;
	assign load_ok = !res_valid_q || !result_stall;
	assign res_load = state_q == ST_DONE && load_ok;

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring[wp_q] <= sample_q;
		end
		ring_rd_q <= ring[wp_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wp_q <= '0;
			fill_q <= '0;
			sum_q <= '0;
			sumsq_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
			if (cfg.clear) begin
				wp_q <= '0;
				fill_q <= '0;
				sum_q <= '0;
				sumsq_q <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (head_valid) begin
						sample_q <= head_cmd.sample;
						pend_q.variance <= '0;
						pend_q.valid_res <= 1'b0;
						pend_q.config_error <= head_cmd.cfg_err;
						state_q <= head_cmd.upd ? ST_READ : ST_DONE;
					end
				end
				ST_READ: begin
					old_q <= fill_full ? ring_rd_q : '0;
					old_sq_q <= fill_full ? old_prod[SQ_W-1:0] : '0;
					new_sq_q <= new_prod[SQ_W-1:0];
					report_q <= fill_next >= cfg.n;
					fill_q <= fill_next;
					if (CNT_W'(wp_q) + CNT_W'(1) == cfg.n) begin
						wp_q <= '0;
					end else begin
						wp_q <= wp_q + PTR_W'(1);
					end
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					sum_q <= sum_q - SUM_W'(old_q) + SUM_W'(sample_q);
					sumsq_q <= sumsq_q - SUMSQ_W'(old_sq_q) + SUMSQ_W'(new_sq_q);
					state_q <= report_q ? ST_MUL : ST_DONE;
				end
				ST_MUL: begin
					prod_a_q <= NUM_W'(sumsq_q) * NUM_W'(cfg.n);
					prod_b_q <= NUM_W'(mag) * NUM_W'(mag);
					den_q <= DEN_W'(cfg.n) * DEN_W'(n_minus_dof);
					state_q <= ST_SUB;
				end
				ST_SUB: begin
					if (!div_busy) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						pend_q.valid_res <= 1'b1;
						if (|div_quo[NUM_W-1:VAR_W]) begin
							pend_q.variance <= '1;
						end else begin
							pend_q.variance <= div_quo[VAR_W-1:0];
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_ok) begin
						res_q <= pend_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	mwv_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num((prod_a_q >= prod_b_q) ? prod_a_q - prod_b_q : '0),
		.den(den_q),
		.busy(div_busy),
		.done(div_done),
		.quotient(div_quo)
	);

	assign result_valid = res_valid_q;
	assign result_item = res_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= cfg.n)
		else $error("fill count exceeds the window length");

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q == '0 || CNT_W'(wp_q) < cfg.n)
		else $error("write pointer outside the window");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && load_ok) |=> res_valid_q)
		else $error("finished item did not reach the result register");

	a_div_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("division finished outside the divide step");

endmodule

`default_nettype wire

// ----- rtl/core/moving_window_variance.sv -----
// Channel  | Direction | Handshake            | Payload
// sample   | in        | sample_valid / stall | sample_item (sample, missing)
// result   | out       | result_valid / stall | result_item (variance, valid_res, config_error)
// cfg      | in        | cfg_valid / ready    | cfg_index, cfg_wdata
//
// The back part takes one item at a time. An item that yields a variance passes through
// read, update, multiply, subtract, the one-bit-a-step divider over the 48-bit numerator
// and done; a filling item skips to done after update, a missing or illegal item at once.
// A two-entry transfer queue separates acceptance from execution.
// Reset empties the window and sets window_len to 256 and dof to 1.
// A finished result waits in the output register while the next item proceeds.
`default_nettype none

module moving_window_variance (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic sample_valid,
	output logic sample_stall,
	input wire mwv_pkg::in_t sample_item,
	output logic result_valid,
	input wire logic result_stall,
	output mwv_pkg::out_t result_item,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [mwv_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [mwv_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import mwv_pkg::*;

	logic queue_full;
	logic push;
	cmd_t push_cmd;
	cfg_t cfg;
	logic pop;
	logic head_valid;
	cmd_t head_cmd;

	mwv_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample_item(sample_item),
		.queue_full(queue_full),
		.push(push),
		.push_cmd(push_cmd),
		.cfg(cfg)
	);

	mwv_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.full(queue_full),
		.pop(pop),
		.head_valid(head_valid),
		.head_cmd(head_cmd)
	);

	mwv_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.head_valid(head_valid),
		.head_cmd(head_cmd),
		.pop(pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_item(result_item)
	);

endmodule

`default_nettype wire

// ----- sim/tb_moving_window_variance.sv -----
`default_nettype none

module tb_moving_window_variance;
	timeunit 1ns;
	timeprecision 1ps;

	import mwv_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1_500_000;
	localparam int unsigned ITEM_TARGET = 1950;
	localparam longint VAR_MAX = (longint'(1) << VAR_W) - 1;

	class variance_scoreboard;
		int ring[MAX_WINDOW];
		int unsigned wr_ptr;
		int unsigned filled;
		int unsigned win_len;
		int unsigned dof_val;
		longint sum;
		longint sum_sq;
		out_t expected_variances[$];
		int errors;

		function new();
			win_len = RESET_WINDOW_LEN;
			dof_val = RESET_DOF;
			errors = 0;
			clear_window();
		endfunction

		function void clear_window();
			foreach (ring[i]) ring[i] = 0;
			wr_ptr = 0;
			filled = 0;
			sum = 0;
			sum_sq = 0;
		endfunction

		function void write_setting(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_WINDOW_LEN) begin
				win_len = data;
			end else begin
				dof_val = data[DOF_W-1:0];
			end
			clear_window();
		endfunction

		function void predict_variance(in_t item);
			int unsigned n;
			bit err;
			longint s;
			longint old;
			longint num;
			longint den;
			longint quo;
			out_t r;
			n = (win_len > MAX_WINDOW) ? MAX_WINDOW : win_len;
			err = (n <= dof_val + 1);
			s = longint'($signed(item.sample));
			r = '0;
			r.config_error = err;
			if (!err && !item.missing) begin
				if (filled < n) begin
					filled++;
				end else begin
					old = ring[wr_ptr];
					sum -= old;
					sum_sq -= old * old;
				end
				ring[wr_ptr] = int'(s);
				wr_ptr = (wr_ptr + 1) % n;
				sum += s;
				sum_sq += s * s;
				if (filled >= n) begin
					num = longint'(n) * sum_sq - sum * sum;
					if (num < 0) num = 0;
					den = longint'(n) * longint'(n - dof_val);
					quo = num / den;
					if (quo > VAR_MAX) quo = VAR_MAX;
					r.variance = quo[VAR_W-1:0];
					r.valid_res = 1'b1;
				end
			end
			expected_variances.push_back(r);
		endfunction

		function void report(string name, logic [VAR_W-1:0] want, logic [VAR_W-1:0] got);
			errors++;
			if (errors <= 50) begin
				$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(out_t got);
			out_t want;
			if (expected_variances.size() == 0) begin
				errors++;
				if (errors <= 50) begin
					$display("%0t: result transfer with none expected, expected nothing actual %h",
						$time, got);
				end
				return;
			end
			want = expected_variances.pop_front();
			if (got.variance !== want.variance) report("variance", want.variance, got.variance);
			if (got.valid_res !== want.valid_res) report("valid_res", want.valid_res, got.valid_res);
			if (got.config_error !== want.config_error) begin
				report("config_error", want.config_error, got.config_error);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic sample_valid;
	logic sample_stall;
	in_t sample_item;
	logic result_valid;
	logic result_stall = 1'b0;
	out_t result_item;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned cycle_count = 0;

	variance_scoreboard sb = new();

	moving_window_variance u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample_item(sample_item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_item(result_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[moving_window_variance] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			sb.check_result(result_item);
		end
	end

	task automatic send_item(in_t item);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_item <= item;
		do @(posedge clk); while (sample_stall);
		sb.predict_variance(item);
	endtask

	task automatic drain();
		sample_valid <= 1'b0;
		while (sb.expected_variances.size() != 0) @(posedge clk);
	endtask

	task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_setting(idx, data);
	endtask

	task automatic configure(logic [CFG_DATA_W-1:0] len, logic [CFG_DATA_W-1:0] dof_data);
		if ($urandom_range(1)) begin
			cfg_write(REG_WINDOW_LEN, len);
			cfg_write(REG_DOF, dof_data);
		end else begin
			cfg_write(REG_DOF, dof_data);
			cfg_write(REG_WINDOW_LEN, len);
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int unsigned total;
		int unsigned phase;
		int unsigned pick;
		int unsigned count;
		int unsigned smode;
		int unsigned wl;
		int unsigned dof8;
		in_t item;

		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample_item = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_WINDOW_LEN;
		cfg_wdata = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(in_t'{sample: 16'h1234, missing: 1'b0});
		send_item(in_t'{sample: 16'hFFFF, missing: 1'b1});
		drain();

		configure(9'd2, 9'd0);
		send_item(in_t'{sample: 16'h7FFF, missing: 1'b0});
		send_item(in_t'{sample: 16'h8000, missing: 1'b0});
		send_item(in_t'{sample: 16'h0000, missing: 1'b1});
		send_item(in_t'{sample: 16'h8000, missing: 1'b0});
		send_item(in_t'{sample: 16'h8000, missing: 1'b0});
		send_item(in_t'{sample: 16'h0000, missing: 1'b0});
		send_item(in_t'{sample: 16'hFFFF, missing: 1'b0});
		send_item(in_t'{sample: 16'h7FFF, missing: 1'b0});
		drain();

		configure(9'd2, 9'd1);
		send_item(in_t'{sample: 16'h0005, missing: 1'b0});
		send_item(in_t'{sample: 16'h7FFF, missing: 1'b1});
		drain();

		configure(9'd0, 9'd0);
		send_item(in_t'{sample: 16'h8000, missing: 1'b0});
		drain();

		configure(9'd1, 9'd0);
		send_item(in_t'{sample: 16'h0001, missing: 1'b0});
		drain();

		configure(9'd3, 9'd1);
		send_item(in_t'{sample: 16'h7FFF, missing: 1'b0});
		send_item(in_t'{sample: 16'h8000, missing: 1'b0});
		send_item(in_t'{sample: 16'h7FFF, missing: 1'b0});
		send_item(in_t'{sample: 16'h0000, missing: 1'b1});
		send_item(in_t'{sample: 16'h8000, missing: 1'b0});
		drain();

		total = 0;
		phase = 0;
		while (total < ITEM_TARGET) begin
			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 78;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 78;
				end
				default: begin
					send_idle_pct = 36;
					stall_pct = 36;
				end
			endcase

			// Full-depth windows are costly, so only two phases fill them; others pair them with an illegal dof.
			pick = $urandom_range(9);
			if (phase == 2) begin
				wl = 256;
				dof8 = 254;
				count = 256 + $urandom_range(20, 40);
			end else if (phase == 5) begin
				wl = 511;
				dof8 = 0;
				count = 256 + $urandom_range(20, 40);
			end else if (pick < 6) begin
				wl = $urandom_range(2, 12);
				dof8 = $urandom_range(0, wl - 2);
				count = wl + $urandom_range(15, 40);
			end else if (pick < 8) begin
				wl = $urandom_range(13, 64);
				dof8 = $urandom_range(0, wl - 2);
				count = wl + $urandom_range(10, 30);
			end else if (pick == 8) begin
				wl = $urandom_range(0, 20);
				dof8 = $urandom_range((wl == 0) ? 0 : wl - 1, 255);
				count = $urandom_range(5, 15);
			end else begin
				wl = $urandom_range(256, 511);
				dof8 = 255;
				count = $urandom_range(5, 15);
			end
			configure(wl[CFG_DATA_W-1:0], {1'($urandom_range(1)), dof8[DOF_W-1:0]});

			smode = $urandom_range(3);
			repeat (count) begin
				item.missing = ($urandom_range(9) == 0);
				case (smode)
					1: begin
						case ($urandom_range(3))
							0: item.sample = 16'h8000;
							1: item.sample = 16'h7FFF;
							2: item.sample = 16'hFFFF;
							default: item.sample = 16'h0000;
						endcase
					end
					2: item.sample = 16'($urandom_range(0, 15)) - 16'd8;
					default: item.sample = 16'($urandom);
				endcase
				send_item(item);
			end
			total += count;
			drain();
			phase++;
		end

		repeat (64) @(posedge clk);
		if (sb.errors == 0) begin
			$display("[moving_window_variance] OK");
		end else begin
			$display("[moving_window_variance] ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/core/mwv_pkg.sv
rtl/core/mwv_front.sv
rtl/core/mwv_queue.sv
rtl/core/mwv_div.sv
rtl/core/mwv_back.sv
rtl/core/moving_window_variance.sv
sim/tb_moving_window_variance.sv
